[design/bsa_pkg.sv]
// Shared widths, codes and a helper function of the bitmap slot allocator.
`timescale 1ns / 1ps
package bsa_pkg;

    localparam int TABLE_ENTRIES_DEF  = 64;
    localparam int SLOTS_PER_PAGE_DEF = 64;

    localparam int PAGE_W     = 36;
    localparam int CNT_W      = 6;
    localparam int OFF_W      = 6;
    localparam int IDX_OUT_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 2;

    localparam int S_TDATA_W  = 88;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd0;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNUSED    = 2'd3;

    // result item layout in m_tdata
    localparam int M_STATUS_LO   = 0;
    localparam int M_IDX_LO      = 2;
    localparam int M_PAGE_LO     = 8;
    localparam int M_OFF_LO      = 44;
    localparam int M_TAKEN_BIT   = 50;
    localparam int M_RELEASE_BIT = 51;

    typedef struct packed {
        logic                 page_released;
        logic                 spare_page_taken;
        logic [OFF_W-1:0]     result_slot_offset;
        logic [PAGE_W-1:0]    result_page_number;
        logic [IDX_OUT_W-1:0] entry_index;
        logic [STATUS_W-1:0]  status;
    } result_t;

    function automatic logic [63:0] run_mask64(input logic [CNT_W-1:0] count);
        run_mask64 = (64'd1 << count) - 64'd1;
    endfunction

endpackage

[design/bsa_fit.sv]
// First-fit search for a run of free slots in one page bitmap.
`timescale 1ns / 1ps
module bsa_fit #(
    parameter int SLOTS_PER_PAGE = bsa_pkg::SLOTS_PER_PAGE_DEF
) (
    input  logic [SLOTS_PER_PAGE-1:0]  slot_map,
    input  logic [bsa_pkg::CNT_W-1:0]  slot_count,
    output logic                       fit_found,
    output logic [bsa_pkg::OFF_W-1:0]  fit_offset,
    output logic [SLOTS_PER_PAGE-1:0]  fit_run
);
    import bsa_pkg::*;

    logic [63:0]               rm64;
    logic [SLOTS_PER_PAGE-1:0] rmask;
    logic [SLOTS_PER_PAGE-1:0] fits;

    assign rm64  = run_mask64(slot_count);
    assign rmask = rm64[SLOTS_PER_PAGE-1:0];

    always_comb begin
        for (int o = 0; o < SLOTS_PER_PAGE; o++) begin
            fits[o] = ((7'(o) + 7'(slot_count)) <= 7'(SLOTS_PER_PAGE)) &&
                      ((slot_map & (rmask << o)) == '0);
        end
    end

    always_comb begin
        fit_found  = 1'b0;
        fit_offset = '0;
        for (int o = SLOTS_PER_PAGE - 1; o >= 0; o--) begin
            if (fits[o]) begin
                fit_found  = 1'b1;
                fit_offset = OFF_W'(o);
            end
        end
    end

    assign fit_run = rmask << fit_offset;

endmodule

[design/bitmap_slot_allocator.sv]
// Top level: slot-run allocator over a page entry table held in one memory.
//
//  channel   dir   tdata                                          tuser
//  s_        in    slot_count, spare_page, freed_page, freed_off  func, pool_kind
//  m_        out   status, entry_index, page, offset, flags       -
//
// An item is accepted, scanned one table entry per cycle (read from the table
// memory) up to the last of TABLE_ENTRIES and answered; an allocate with a bad
// count skips the scan. After reset a clearing pass over every entry runs with
// s_tready low. A stalled m_ side holds the finished item in the response
// state; the next item is taken while the result waits in the output register.
`timescale 1ns / 1ps
module bitmap_slot_allocator #(
    parameter int TABLE_ENTRIES  = bsa_pkg::TABLE_ENTRIES_DEF,
    parameter int SLOTS_PER_PAGE = bsa_pkg::SLOTS_PER_PAGE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot_count, spare_page_number, freed_page_number, freed_slot_offset
    input  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
    // func, pool_kind
    input  logic [bsa_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, entry_index, result_page_number, result_slot_offset,
    // spare_page_taken, page_released
    output logic [bsa_pkg::M_TDATA_W-1:0] m_tdata
);
    import bsa_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_W = PAGE_W + KIND_W + SLOTS_PER_PAGE;
    localparam int KIND_LO = SLOTS_PER_PAGE;
    localparam int PAGE_LO = SLOTS_PER_PAGE + KIND_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        FSM_CLEAR = 4'b0001,
        FSM_IDLE  = 4'b0010,
        FSM_SCAN  = 4'b0100,
        FSM_RESP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic              req_func_reg, req_func_next;
    logic [KIND_W-1:0] req_kind_reg, req_kind_next;
    logic [CNT_W-1:0]  req_count_reg, req_count_next;
    logic [PAGE_W-1:0] req_spare_reg, req_spare_next;
    logic [PAGE_W-1:0] req_fpage_reg, req_fpage_next;
    logic [OFF_W-1:0]  req_foff_reg, req_foff_next;

    result_t res_reg, res_next;
    logic    m_tvalid_reg, m_tvalid_next;
    result_t m_data_reg, m_data_next;

    logic [ENT_W-1:0] table_mem [TABLE_ENTRIES];
    logic [ENT_W-1:0] rdata_reg;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [ENT_W-1:0] mem_wdata;

    logic [SLOTS_PER_PAGE-1:0] e_map;
    logic [KIND_W-1:0]         e_kind;
    logic [PAGE_W-1:0]         e_page;
    logic [63:0]               rm64;
    logic [SLOTS_PER_PAGE-1:0] rmask;
    logic [SLOTS_PER_PAGE-1:0] free_map;
    logic                      fit_found;
    logic [OFF_W-1:0]          fit_offset;
    logic [SLOTS_PER_PAGE-1:0] fit_run;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
    logic [IDX_OUT_W-1:0]      idx_out;
    logic                      s_func, s_kind_bit;
    logic [CNT_W-1:0]          s_count;
    logic                      bad_count;

    assign s_count    = s_tdata[5:0];
    assign s_func     = s_tuser[0];
    assign s_kind_bit = s_tuser[1];
    assign bad_count  = (s_count == '0) || (7'(s_count) > 7'(SLOTS_PER_PAGE));

    assign e_map  = rdata_reg[SLOTS_PER_PAGE-1:0];
    assign e_kind = rdata_reg[KIND_LO +: KIND_W];
    assign e_page = rdata_reg[PAGE_LO +: PAGE_W];

    assign rm64     = run_mask64(req_count_reg);
    assign rmask    = rm64[SLOTS_PER_PAGE-1:0];
    assign free_map = e_map & ~(rmask << req_foff_reg);

    assign idx_ext = {{IDX_OUT_W{1'b0}}, idx_reg};
    assign idx_out = idx_ext[IDX_OUT_W-1:0];

    bsa_fit #(
        .SLOTS_PER_PAGE(SLOTS_PER_PAGE)
    ) u_fit (
        .slot_map   (e_map),
        .slot_count (req_count_reg),
        .fit_found  (fit_found),
        .fit_offset (fit_offset),
        .fit_run    (fit_run)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= table_mem[mem_raddr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_func_next  = req_func_reg;
        req_kind_next  = req_kind_reg;
        req_count_next = req_count_reg;
        req_spare_next = req_spare_reg;
        req_fpage_next = req_fpage_reg;
        req_foff_next  = req_foff_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        s_tready       = 1'b0;

        case (state_reg)
            FSM_CLEAR: begin
                mem_we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_func_next  = s_func;
                    req_kind_next  = {1'b0, s_kind_bit} + 2'd1;
                    req_count_next = s_count;
                    req_spare_next = s_tdata[41:6];
                    req_fpage_next = s_tdata[77:42];
                    req_foff_next  = s_tdata[83:78];
                    res_next        = '0;
                    if (s_func == FUNC_ALLOC && bad_count) begin
                        res_next.status = STAT_FULL;
                        state_next      = FSM_RESP;
                    end else begin
                        mem_re     = 1'b1;
                        idx_next   = '0;
                        state_next = FSM_SCAN;
                    end
                end
            end
            FSM_SCAN: begin
                res_next = '0;
                if (req_func_reg == FUNC_ALLOC && e_kind == KIND_UNUSED) begin
                    mem_we    = 1'b1;
                    mem_wdata = {req_spare_reg, req_kind_reg, rmask};
                    res_next.status             = STAT_DONE;
                    res_next.entry_index        = idx_out;
                    res_next.result_page_number = req_spare_reg;
                    res_next.spare_page_taken   = 1'b1;
                    state_next = FSM_RESP;
                end else if (req_func_reg == FUNC_ALLOC && e_kind == req_kind_reg &&
                             fit_found) begin
                    mem_we    = 1'b1;
                    mem_wdata = {e_page, e_kind, e_map | fit_run};
                    res_next.status             = STAT_DONE;
                    res_next.entry_index        = idx_out;
                    res_next.result_page_number = e_page;
                    res_next.result_slot_offset = fit_offset;
                    state_next = FSM_RESP;
                end else if (req_func_reg == FUNC_FREE && e_kind != KIND_UNUSED &&
                             e_page == req_fpage_reg) begin
                    mem_we = 1'b1;
                    if (free_map == '0) begin
                        mem_wdata              = '0;
                        res_next.page_released = 1'b1;
                    end else begin
                        mem_wdata = {e_page, e_kind, free_map};
                    end
                    res_next.status      = STAT_DONE;
                    res_next.entry_index = idx_out;
                    state_next = FSM_RESP;
                end else if (idx_reg == LAST_IDX) begin
                    res_next.status = (req_func_reg == FUNC_ALLOC) ? STAT_FULL
                                                                   : STAT_NOT_FOUND;
                    state_next = FSM_RESP;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            FSM_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = res_reg;
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_CLEAR;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_func_reg  <= req_func_next;
        req_kind_reg  <= req_kind_next;
        req_count_reg <= req_count_next;
        req_spare_reg <= req_spare_next;
        req_fpage_reg <= req_fpage_next;
        req_foff_reg  <= req_foff_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

endmodule

[design/bsa_checker.sv]
// Port-level checks of the bitmap slot allocator result channel.
`timescale 1ns / 1ps
module bsa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [bsa_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bsa_pkg::M_TDATA_W-1:0] m_tdata
);
    import bsa_pkg::*;

    logic [STATUS_W-1:0] m_status;
    logic                m_taken;
    logic                m_released;
    logic [OFF_W-1:0]    m_off;

    assign m_status   = m_tdata[M_STATUS_LO +: STATUS_W];
    assign m_taken    = m_tdata[M_TAKEN_BIT];
    assign m_released = m_tdata[M_RELEASE_BIT];
    assign m_off      = m_tdata[M_OFF_LO +: OFF_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_status != STAT_UNUSED)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_status != STAT_DONE |-> m_tdata[M_TDATA_W-1:M_IDX_LO] == '0)
        else $error("failed item carries nonzero fields");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_taken |-> !m_released && m_off == '0)
        else $error("new page claim with release flag or nonzero offset");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("accepting an item disturbed a waiting result");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

[tb/bsa_checker.sv]
// Slot table tracker that works out each grant and compares it with the result channel.
`timescale 1ns / 1ps
module bsa_scoreboard #(
    parameter int ENTRIES = bsa_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // slot_count, spare_page_number, freed_page_number, freed_slot_offset
    input  logic [bsa_pkg::S_TDATA_W-1:0] s_tdata,
    // func, pool_kind
    input  logic [bsa_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status, entry_index, result_page_number, result_slot_offset,
    // spare_page_taken, page_released
    input  logic [bsa_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            owed_count,
    output int                            result_total,
    output int                            full_total,
    output int                            missing_total,
    output int                            release_total
);

    logic [bsa_pkg::PAGE_W-1:0] slab_page [ENTRIES];
    logic [bsa_pkg::KIND_W-1:0] slab_kind [ENTRIES];
    logic [63:0]                slab_map  [ENTRIES];

    bsa_pkg::result_t owed_grants[$];
    int mismatches = 0;
    int results    = 0;
    int fulls      = 0;
    int misses     = 0;
    int releases   = 0;

    function automatic bsa_pkg::result_t serve_request(
        input logic                       func,
        input logic                       pool_kind,
        input logic [bsa_pkg::CNT_W-1:0]  cnt,
        input logic [bsa_pkg::PAGE_W-1:0] spare,
        input logic [bsa_pkg::PAGE_W-1:0] fpage,
        input logic [bsa_pkg::OFF_W-1:0]  foff
    );
        bsa_pkg::result_t           r;
        logic [63:0]                run;
        logic [bsa_pkg::KIND_W-1:0] want_kind;
        int                         i;
        int                         o;
        r         = '0;
        run       = (cnt == '0) ? 64'd0 : ({64{1'b1}} >> (64 - int'(cnt)));
        want_kind = {1'b0, pool_kind} + 2'd1;
        if (func == bsa_pkg::FUNC_ALLOC) begin
            if (cnt == '0) begin
                r.status = bsa_pkg::STAT_FULL;
                return r;
            end
            for (i = 0; i < ENTRIES; i++) begin
                if (slab_kind[i] == bsa_pkg::KIND_UNUSED) begin
                    slab_page[i]         = spare;
                    slab_kind[i]         = want_kind;
                    slab_map[i]          = run;
                    r.status             = bsa_pkg::STAT_DONE;
                    r.entry_index        = i[5:0];
                    r.result_page_number = spare;
                    r.spare_page_taken   = 1'b1;
                    return r;
                end
                if (slab_kind[i] == want_kind) begin
                    for (o = 0; o <= 64 - int'(cnt); o++) begin
                        if ((slab_map[i] & (run << o)) == 64'd0) begin
                            slab_map[i]          = slab_map[i] | (run << o);
                            r.status             = bsa_pkg::STAT_DONE;
                            r.entry_index        = i[5:0];
                            r.result_page_number = slab_page[i];
                            r.result_slot_offset = o[5:0];
                            return r;
                        end
                    end
                end
            end
            r.status = bsa_pkg::STAT_FULL;
            return r;
        end
        for (i = 0; i < ENTRIES; i++) begin
            if (slab_kind[i] != bsa_pkg::KIND_UNUSED && slab_page[i] == fpage) begin
                slab_map[i]   = slab_map[i] & ~(run << foff);
                r.status      = bsa_pkg::STAT_DONE;
                r.entry_index = i[5:0];
                if (slab_map[i] == 64'd0) begin
                    slab_kind[i]    = bsa_pkg::KIND_UNUSED;
                    slab_page[i]    = '0;
                    r.page_released = 1'b1;
                end
                return r;
            end
        end
        r.status = bsa_pkg::STAT_NOT_FOUND;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        bsa_pkg::result_t got;
        bsa_pkg::result_t want;
        int               i;
        if (!aresetn) begin
            for (i = 0; i < ENTRIES; i++) begin
                slab_page[i] = '0;
                slab_kind[i] = bsa_pkg::KIND_UNUSED;
                slab_map[i]  = 64'd0;
            end
            owed_grants.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(bsa_pkg::result_t)-1:0];
                results++;
                if (got.status == bsa_pkg::STAT_FULL) fulls++;
                if (got.status == bsa_pkg::STAT_NOT_FOUND) misses++;
                if (got.page_released) releases++;
                if (owed_grants.size() == 0) begin
                    $error("result item with no request outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = owed_grants.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("entry_index", want.entry_index, got.entry_index);
                    compare_field("result_page_number", want.result_page_number,
                                  got.result_page_number);
                    compare_field("result_slot_offset", want.result_slot_offset,
                                  got.result_slot_offset);
                    compare_field("spare_page_taken", want.spare_page_taken,
                                  got.spare_page_taken);
                    compare_field("page_released", want.page_released, got.page_released);
                end
            end
            if (s_tvalid && s_tready) begin
                owed_grants.push_back(serve_request(s_tuser[0], s_tuser[1], s_tdata[5:0],
                                                    s_tdata[41:6], s_tdata[77:42],
                                                    s_tdata[83:78]));
            end
        end
        owed_count    <= owed_grants.size();
        fail_count    <= mismatches;
        result_total  <= results;
        full_total    <= fulls;
        missing_total <= misses;
        release_total <= releases;
    end

endmodule

[tb/tb_bitmap_slot_allocator.sv]
// Stimulus, clock, reset and verdict for the bitmap slot allocator.
`timescale 1ns / 1ps
module tb_bitmap_slot_allocator;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_ITEMS = 1030;
    localparam int SEGMENT_LEN  = 80;
    localparam int HOLD_CYCLES  = 1500;
    localparam int HOLD_AT_ITEM = 400;
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 760;
    localparam int DRAIN_WAIT   = 80;
    localparam int POOL_SIZE    = 24;
    localparam int PAD_W        = bsa_pkg::S_TDATA_W - 84;

    localparam logic POOL_NX   = 1'b0;
    localparam logic POOL_EXEC = 1'b1;

    localparam logic [35:0] PAGE_ZERO = 36'h0;
    localparam logic [35:0] PAGE_TOP  = 36'hFFFFFFFFF;
    localparam logic [35:0] PAGE_A    = 36'h123456789;
    localparam logic [35:0] PAGE_B    = 36'hA5A5A5A5A;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_NOISE} mix_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bsa_pkg::S_TDATA_W-1:0] s_tdata;
    logic [bsa_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bsa_pkg::M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int owed_count;
    int result_total;
    int full_total;
    int missing_total;
    int release_total;

    int          sent_items  = 0;
    bit          idle_en     = 1'b1;
    int          cycle_count = 0;
    logic [35:0] page_pool [POOL_SIZE];

    bitmap_slot_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bsa_scoreboard u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .owed_count    (owed_count),
        .result_total  (result_total),
        .full_total    (full_total),
        .missing_total (missing_total),
        .release_total (release_total)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [35:0] rand_page();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[35:0];
    endfunction

    task automatic offer(input logic func, input logic kind, input logic [5:0] cnt,
                         input logic [35:0] spare, input logic [35:0] fpage,
                         input logic [5:0] foff);
        while (idle_en && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, foff, fpage, spare, cnt};
        s_tuser  <= {kind, func};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    task automatic random_item(input mix_t mix);
        logic        func;
        logic [5:0]  cnt;
        logic [5:0]  foff;
        logic [35:0] spare;
        logic [35:0] fpage;
        int          roll;
        int          stray;
        roll  = $urandom_range(99);
        stray = (mix == MIX_NOISE) ? 60 : 8;
        case (mix)
            MIX_FILL:  func = (roll < 85) ? bsa_pkg::FUNC_ALLOC : bsa_pkg::FUNC_FREE;
            MIX_DRAIN: func = (roll < 80) ? bsa_pkg::FUNC_FREE : bsa_pkg::FUNC_ALLOC;
            default:   func = (roll < 50) ? bsa_pkg::FUNC_ALLOC : bsa_pkg::FUNC_FREE;
        endcase
        roll = $urandom_range(99);
        if (roll < 50)      cnt = 6'($urandom_range(63, 17));
        else if (roll < 95) cnt = 6'($urandom_range(16, 1));
        else                cnt = '0;
        foff  = ($urandom_range(99) < 40) ? 6'd0 : 6'($urandom_range(63));
        spare = ($urandom_range(99) < stray) ? rand_page()
                                              : page_pool[$urandom_range(POOL_SIZE - 1)];
        fpage = ($urandom_range(99) < stray) ? rand_page()
                                              : page_pool[$urandom_range(POOL_SIZE - 1)];
        offer(func, 1'($urandom_range(1)), cnt, spare, fpage, foff);
    endtask

    // receiver: random back-pressure, one long hold-off while requests keep coming
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent_items >= HOLD_AT_ITEM) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(99) < 22) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int   n;
        mix_t mix;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        page_pool[0] = PAGE_ZERO;
        page_pool[1] = PAGE_TOP;
        page_pool[2] = PAGE_A;
        page_pool[3] = PAGE_B;
        for (n = 4; n < POOL_SIZE; n++) page_pool[n] = rand_page();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd1,  rand_page(), PAGE_ZERO, 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd0,  PAGE_A,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd63, PAGE_TOP,    rand_page(), 6'd63);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd1,  PAGE_A,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd1,  PAGE_A,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_EXEC, 6'd5,  PAGE_ZERO,   rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_EXEC, 6'd3,  PAGE_B,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd63, rand_page(), PAGE_TOP,  6'd1);
        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd63, rand_page(), PAGE_TOP,  6'd40);
        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd1,  rand_page(), PAGE_TOP,  6'd0);
        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd1,  rand_page(), PAGE_TOP,  6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_EXEC, 6'd63, PAGE_B,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_FREE,  POOL_EXEC, 6'd8,  rand_page(), PAGE_ZERO, 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd32, PAGE_TOP,    rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_FREE,  POOL_NX,   6'd0,  rand_page(), PAGE_A,    6'd10);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd31, PAGE_TOP,    rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_NX,   6'd63, rand_page(), rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_ALLOC, POOL_EXEC, 6'd1,  PAGE_A,      rand_page(), 6'd0);
        offer(bsa_pkg::FUNC_FREE,  POOL_EXEC, 6'd63, rand_page(), PAGE_B,    6'd63);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / SEGMENT_LEN) % 6)
                0, 1:    mix = MIX_FILL;
                2:       mix = MIX_BALANCED;
                3, 4:    mix = MIX_DRAIN;
                default: mix = MIX_NOISE;
            endcase
            idle_en = !(n >= CALM_FROM && n < CALM_TO);
            random_item(mix);
        end
        s_tvalid <= 1'b0;
        idle_en = 1'b1;

        @(posedge aclk);
        while (owed_count != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Run covered %0d requests and %0d results: %0d table full, %0d page misses,",
                 sent_items, result_total, full_total, missing_total);
        $display("%0d page releases, one %0d-cycle receiver hold-off and an idle-free stretch.",
                 release_total, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
